// ----- src/i2c_master_bit_engine_defines.svh -----
// Assertion macros used by the checker of the I2C bit engine.
`ifndef I2C_MASTER_BIT_ENGINE_DEFINES_SVH
`define I2C_MASTER_BIT_ENGINE_DEFINES_SVH

// Property checked at every clock edge outside reset.
`define I2CBE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Property checked at every clock edge, reset included.
`define I2CBE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ----- src/i2cbe_pkg.sv -----
package i2cbe_pkg;

  typedef enum logic [2:0] {
    CmdNone  = 3'd0,
    CmdStart = 3'd1,
    CmdStop  = 3'd2,
    CmdWrite = 3'd3,
    CmdRead  = 3'd4
  } cmd_e;

  localparam int unsigned BitsPerByte = 8;
  localparam logic [7:0]  MsbMask     = 8'(1 << 7);

  // One classified bus tick.
  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda;
    logic       scl;
  } tick_t;

  // Line drive and status after one tick.
  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       done;
    logic [7:0] rx_byte;
    logic       ack_seen;
  } result_t;

endpackage

// ----- src/i2c_master_bit_engine.sv -----
// I2C master line engine.
// Input channel (in_valid_i/in_ready_o): one transfer is one bus tick with a
// command request (func_i: none, start, stop, write byte, read byte), the byte
// to write, the ack choice for a read and the sampled SDA and SCL levels.
// Output channel (out_valid_o/out_ready_i): exactly one result transfer per
// input tick, in order, with the SCL/SDA drive levels, busy, done, the last
// read byte and the ack seen on the last write.
// Requests made while a command runs are dropped; unused codes mean no request.
// A tick is written into the tick queue at its transfer; the sequencer then
// loads its result into the result register. Throughput: one tick per clock
// while results are taken; the line sequencer retires a queued tick per cycle.
// Reset clears the queue, returns the sequencer to idle with both lines
// released and clears the stored read byte and ack flag.
// When the receiver stalls the result register holds and the tick queue
// (QueueDepth entries) keeps taking ticks; in_ready_o drops once it is full.
module i2c_master_bit_engine import i2cbe_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] func_i,
  input  logic [7:0] tx_byte_i,
  input  logic       send_ack_i,
  input  logic       sda_in_i,
  input  logic       scl_in_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       scl_out_o,
  output logic       sda_out_o,
  output logic       busy_res_o,
  output logic       done_res_o,
  output logic [7:0] rx_byte_o,
  output logic       ack_seen_o
);

  tick_t   front_tick;
  tick_t   queue_tick;
  logic    queue_full;
  logic    queue_empty;
  logic    queue_pop;
  result_t res;

  // Front: classify the request code.
  i2cbe_front u_front (
    .func_i     (func_i),
    .tx_byte_i  (tx_byte_i),
    .send_ack_i (send_ack_i),
    .sda_in_i   (sda_in_i),
    .scl_in_i   (scl_in_i),
    .tick_o     (front_tick)
  );

  assign in_ready_o = !queue_full;

  // Tick queue decouples the input side from the sequencer.
  i2cbe_fifo #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_valid_i),
    .wdata_i (front_tick),
    .full_o  (queue_full),
    .pop_i   (queue_pop),
    .rdata_o (queue_tick),
    .empty_o (queue_empty)
  );

  // Back: line sequencer with its result register.
  i2cbe_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tick_valid_i (!queue_empty),
    .tick_i       (queue_tick),
    .tick_pop_o   (queue_pop),
    .res_valid_o  (out_valid_o),
    .res_ready_i  (out_ready_i),
    .res_o        (res)
  );

  assign scl_out_o  = res.scl;
  assign sda_out_o  = res.sda;
  assign busy_res_o = res.busy;
  assign done_res_o = res.done;
  assign rx_byte_o  = res.rx_byte;
  assign ack_seen_o = res.ack_seen;

endmodule

// ----- src/i2cbe_front.sv -----
module i2cbe_front import i2cbe_pkg::*; (
  input  logic [2:0] func_i,
  input  logic [7:0] tx_byte_i,
  input  logic       send_ack_i,
  input  logic       sda_in_i,
  input  logic       scl_in_i,
  output tick_t      tick_o
);

  cmd_e cmd;

  // Unused codes collapse to no request.
  always_comb begin
    unique case (func_i)
      CmdStart: cmd = CmdStart;
      CmdStop:  cmd = CmdStop;
      CmdWrite: cmd = CmdWrite;
      CmdRead:  cmd = CmdRead;
      default:  cmd = CmdNone;
    endcase
  end

  assign tick_o.cmd      = cmd;
  assign tick_o.tx_byte  = tx_byte_i;
  assign tick_o.send_ack = send_ack_i;
  assign tick_o.sda      = sda_in_i;
  assign tick_o.scl      = scl_in_i;

endmodule

// ----- src/i2cbe_fifo.sv -----
module i2cbe_fifo import i2cbe_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  tick_t wdata_i,
  output logic  full_o,
  input  logic  pop_i,
  output tick_t rdata_o,
  output logic  empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  tick_t            mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == LastPtr) ? '0 : wptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == LastPtr) ? '0 : rptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// ----- src/i2cbe_engine.sv -----
module i2cbe_engine import i2cbe_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    tick_valid_i,
  input  tick_t   tick_i,
  output logic    tick_pop_o,
  output logic    res_valid_o,
  input  logic    res_ready_i,
  output result_t res_o
);

  // Step codes per command.
  localparam logic [3:0] StSdaHi = 4'd0, StSclHi = 4'd1, StSdaLo = 4'd2;
  localparam logic [3:0] SpSdaLo = 4'd0, SpSclHi = 4'd1;
  localparam logic [3:0] WrData = 4'd0, WrSclHi = 4'd1, WrSclLo = 4'd2,
                         WrRel = 4'd3, WrAckHi = 4'd4;
  localparam logic [3:0] RdRel = 4'd0, RdSclHi = 4'd1, RdWait = 4'd2,
                         RdSample = 4'd3, RdSclLo = 4'd4, RdAckDrv = 4'd5,
                         RdAckHi = 4'd6, RdAckLo = 4'd7;

  cmd_e       cmd_q, cmd_d;
  logic [3:0] step_q, step_d;
  logic [3:0] bit_q, bit_d;
  logic [7:0] shift_q, shift_d;
  logic       ackc_q, ackc_d;
  logic       ackf_q, ackf_d;
  logic       scl_q, scl_d;
  logic       sda_q, sda_d;
  logic [7:0] rx_q, rx_d;
  logic       done;
  logic       res_valid_q;
  result_t    res_q, res_d;

  assign tick_pop_o = tick_valid_i && (!res_valid_q || res_ready_i);

  always_comb begin
    cmd_d   = cmd_q;
    step_d  = step_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    ackc_d  = ackc_q;
    ackf_d  = ackf_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    rx_d    = rx_q;
    done    = 1'b0;

    // Latch a new request only when idle.
    if (cmd_q == CmdNone && tick_i.cmd != CmdNone) begin
      cmd_d  = tick_i.cmd;
      step_d = '0;
      bit_d  = '0;
      if (tick_i.cmd == CmdWrite) shift_d = tick_i.tx_byte;
      if (tick_i.cmd == CmdRead)  ackc_d  = tick_i.send_ack;
    end

    unique case (cmd_d)
      CmdNone: ;
      CmdStart: begin
        unique case (step_d)
          StSdaHi: begin sda_d = 1'b1; step_d = step_d + 4'd1; end
          StSclHi: begin scl_d = 1'b1; step_d = step_d + 4'd1; end
          StSdaLo: begin sda_d = 1'b0; step_d = step_d + 4'd1; end
          default: begin scl_d = 1'b0; done = 1'b1; end
        endcase
      end
      CmdStop: begin
        unique case (step_d)
          SpSdaLo: begin sda_d = 1'b0; step_d = step_d + 4'd1; end
          SpSclHi: begin scl_d = 1'b1; step_d = step_d + 4'd1; end
          default: begin sda_d = 1'b1; done = 1'b1; end
        endcase
      end
      CmdWrite: begin
        unique case (step_d)
          WrData: begin
            sda_d   = |(shift_d & MsbMask);
            shift_d = {shift_d[6:0], 1'b0};
            step_d  = WrSclHi;
          end
          WrSclHi: begin scl_d = 1'b1; step_d = WrSclLo; end
          WrSclLo: begin
            scl_d  = 1'b0;
            bit_d  = bit_d + 4'd1;
            step_d = (bit_d >= 4'(BitsPerByte)) ? WrRel : WrData;
          end
          WrRel:   begin sda_d = 1'b1; step_d = WrAckHi; end
          WrAckHi: begin scl_d = 1'b1; step_d = step_d + 4'd1; end
          default: begin
            ackf_d = !tick_i.sda;
            scl_d  = 1'b0;
            done   = 1'b1;
          end
        endcase
      end
      CmdRead: begin
        unique case (step_d)
          RdRel: begin
            sda_d   = 1'b1;
            shift_d = '0;
            bit_d   = '0;
            step_d  = RdSclHi;
          end
          RdSclHi: begin scl_d = 1'b1; step_d = RdWait; end
          RdWait: begin
            // Slave may stretch the clock; hold until SCL reads high.
            scl_d = 1'b1;
            if (tick_i.scl) step_d = RdSample;
          end
          RdSample: begin
            shift_d = {shift_d[6:0], tick_i.sda};
            step_d  = RdSclLo;
          end
          RdSclLo: begin
            scl_d  = 1'b0;
            bit_d  = bit_d + 4'd1;
            step_d = (bit_d >= 4'(BitsPerByte)) ? RdAckDrv : RdSclHi;
          end
          RdAckDrv: begin sda_d = !ackc_d; step_d = RdAckHi; end
          RdAckHi:  begin scl_d = 1'b1; step_d = RdAckLo; end
          RdAckLo:  begin scl_d = 1'b0; step_d = step_d + 4'd1; end
          default: begin
            sda_d = 1'b1;
            rx_d  = shift_d;
            done  = 1'b1;
          end
        endcase
      end
      default: begin
        cmd_d  = CmdNone;
        step_d = '0;
      end
    endcase

    if (done) begin
      cmd_d  = CmdNone;
      step_d = '0;
      bit_d  = '0;
    end

    res_d.scl      = scl_d;
    res_d.sda      = sda_d;
    res_d.busy     = (cmd_d != CmdNone);
    res_d.done     = done;
    res_d.rx_byte  = rx_d;
    res_d.ack_seen = ackf_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q       <= CmdNone;
      step_q      <= '0;
      bit_q       <= '0;
      shift_q     <= '0;
      ackc_q      <= 1'b0;
      ackf_q      <= 1'b0;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      rx_q        <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (tick_pop_o) begin
        cmd_q   <= cmd_d;
        step_q  <= step_d;
        bit_q   <= bit_d;
        shift_q <= shift_d;
        ackc_q  <= ackc_d;
        ackf_q  <= ackf_d;
        scl_q   <= scl_d;
        sda_q   <= sda_d;
        rx_q    <= rx_d;
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_pop_o) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ----- src/i2cbe_sva.sv -----
`include "i2c_master_bit_engine_defines.svh"

module i2cbe_sva (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       scl_out_o,
  input logic       sda_out_o,
  input logic       busy_res_o,
  input logic       done_res_o,
  input logic [7:0] rx_byte_o,
  input logic       ack_seen_o
);

  `I2CBE_ASSERT_ALWAYS(a_no_result_in_reset, !rst_ni |=> !out_valid_o, "result valid in reset")

  `I2CBE_ASSERT(a_done_not_busy, out_valid_o && done_res_o |-> !busy_res_o, "done while busy")

  `I2CBE_ASSERT(a_result_holds, out_valid_o && !out_ready_i |=> out_valid_o && $stable({scl_out_o, sda_out_o, busy_res_o, done_res_o, rx_byte_o, ack_seen_o}), "stalled result changed")

  `I2CBE_ASSERT(a_first_after_reset, $rose(rst_ni) |-> !out_valid_o && in_ready_o, "bad state after reset")

endmodule

bind i2c_master_bit_engine i2cbe_sva u_i2cbe_sva (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .scl_out_o   (scl_out_o),
  .sda_out_o   (sda_out_o),
  .busy_res_o  (busy_res_o),
  .done_res_o  (done_res_o),
  .rx_byte_o   (rx_byte_o),
  .ack_seen_o  (ack_seen_o)
);
